// ----- sv/tce_pkg.sv -----
package tce_pkg;

  localparam int DEF_DATA_DEPTH  = 65536;
  localparam int DEF_STACK_DEPTH = 1024;
  localparam int DEF_FRAME_DEPTH = 64;

  localparam int PC_W   = 24;
  localparam int WORD_W = 16;

  typedef enum logic [4:0] {
    OP_HLT    = 5'd0,
    OP_JMP    = 5'd1,
    OP_CJMP   = 5'd2,
    OP_OJMP   = 5'd3,
    OP_CALL   = 5'd4,
    OP_RET    = 5'd5,
    OP_PUSH   = 5'd6,
    OP_POP    = 5'd7,
    OP_LOADB  = 5'd8,
    OP_LOADW  = 5'd9,
    OP_STOREB = 5'd10,
    OP_STOREW = 5'd11,
    OP_LOADI  = 5'd12,
    OP_NOP    = 5'd13,
    OP_IN     = 5'd14,
    OP_OUT    = 5'd15,
    OP_ADD    = 5'd16,
    OP_ADDI   = 5'd17,
    OP_SUB    = 5'd18,
    OP_SUBI   = 5'd19,
    OP_MUL    = 5'd20,
    OP_DIV    = 5'd21,
    OP_AND    = 5'd22,
    OP_OR     = 5'd23,
    OP_XOR    = 5'd24,
    OP_NOTB   = 5'd25,
    OP_SAL    = 5'd26,
    OP_SAR    = 5'd27,
    OP_EQU    = 5'd28,
    OP_LT     = 5'd29,
    OP_LTE    = 5'd30,
    OP_NOTC   = 5'd31
  } op_t;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_POP_R0 = 2'd1;
  localparam logic [1:0] FAULT_DIV0   = 2'd2;

  localparam logic REQ_EXEC    = 1'b0;
  localparam logic REQ_PRELOAD = 1'b1;

endpackage

// ----- sv/tce_if.sv -----
interface tce_in_if;
  import tce_pkg::*;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] instr_word;
  logic [7:0]  in_byte;
  logic [15:0] load_addr;
  logic [7:0]  load_byte;

  modport source (output valid, req_type, instr_word, in_byte, load_addr, load_byte,
                  input ready);
  modport sink (input valid, req_type, instr_word, in_byte, load_addr, load_byte,
                output ready);
endinterface

interface tce_out_if;
  import tce_pkg::*;
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] next_pc;
  logic            out_valid;
  logic [7:0]      out_byte;
  logic            halted;
  logic [1:0]      fault;
  logic            compare_flag;
  logic            overflow_flag;

  modport source (output valid, next_pc, out_valid, out_byte, halted, fault, compare_flag,
                  overflow_flag, input ready);
  modport sink (input valid, next_pc, out_valid, out_byte, halted, fault, compare_flag,
                overflow_flag, output ready);
endinterface

// ----- sv/teaching_cpu_execute_unit.sv -----
// Execute unit of a small teaching processor. Each input transaction carries either one
// instruction word or one data memory preload byte, and every input transaction returns
// exactly one result transaction with the next PC, console output, halt/fault status and
// flags. The unit works on one transaction at a time: ALU, branch, push/pop and store-byte
// instructions pass through accept, register read, execute and result register; LOADB and
// STOREW add one memory step, LOADW two, CALL and RET move one register per cycle through
// the frame memory port, DIV computes one quotient bit per cycle in the divide step, and
// preload or any item after a halt goes from accept to the result register. A new
// transaction may be accepted while the previous result still waits on the output.
// DATA_DEPTH, STACK_DEPTH and FRAME_DEPTH must be powers of two; data, stack and frame memories are not initialized.
module teaching_cpu_execute_unit import tce_pkg::*; #(
  parameter int DATA_DEPTH  = DEF_DATA_DEPTH,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int FRAME_DEPTH = DEF_FRAME_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  tce_in_if.sink   in_ch,
  tce_out_if.source out_ch
);

  localparam int DATA_AW  = $clog2(DATA_DEPTH);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int FRAME_AW = $clog2(FRAME_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD2, S_EX, S_LD1, S_LD2, S_ST2, S_CSAVE, S_RLOAD, S_DIV, S_FIN
  } state_t;

  state_t state_r;

  logic [31:0]         ir_r;
  logic [7:0]          inb_r;
  logic [PC_W-1:0]     pc_r;
  logic                cmp_r, ovf_r, stopped_r;
  logic [STACK_AW-1:0] sp_r;
  logic [FRAME_AW-1:0] fp_r;
  logic [WORD_W-1:0]   opa_r, opb_r;
  logic [DATA_AW-1:0]  dadr_r;
  logic [7:0]          hi_r;
  logic [3:0]          cnt_r;
  logic [16:0]         rem_r;
  logic [WORD_W-1:0]   quo_r, dvs_r;
  logic                neg_r;
  logic                res_ov_r;
  logic [7:0]          res_ob_r;
  logic [1:0]          res_flt_r;

  logic                out_v_r;
  logic [PC_W-1:0]     o_pc_r;
  logic                o_ov_r, o_halt_r, o_cmp_r, o_ovf_r;
  logic [7:0]          o_ob_r;
  logic [1:0]          o_flt_r;

  // Register file with per-entry valid bits so that reset reads as zero.
  logic [WORD_W-1:0] rf_mem [8];
  logic [7:0]        rf_vld_r;
  logic [2:0]        rfa_addr, rfb_addr, rf_wa;
  logic              rf_we;
  logic [WORD_W-1:0] rf_wd, rfa_q, rfb_q;

  logic [7:0]         dm_mem [DATA_DEPTH];
  logic               dm_we;
  logic [DATA_AW-1:0] dm_wa, dm_ra;
  logic [7:0]         dm_wd, dm_q;

  logic [WORD_W-1:0]   st_mem [STACK_DEPTH];
  logic                st_we;
  logic [WORD_W-1:0]   st_q;

  logic [WORD_W-1:0]     fr_mem [FRAME_DEPTH*8];
  logic                  fr_we;
  logic [FRAME_AW+2:0]   fr_wa, fr_ra;
  logic [WORD_W-1:0]     fr_q;
  logic [PC_W+1:0]       fm_mem [FRAME_DEPTH];
  logic                  fm_we;
  logic [FRAME_AW-1:0]   fm_ra;
  logic [PC_W+1:0]       fm_q;

  op_t               op;
  logic [2:0]        rd;
  logic [WORD_W-1:0] imm;
  logic [PC_W-1:0]   addr;
  logic [PC_W-1:0]   dadr24;
  logic [DATA_AW-1:0] ex_dadr;

  assign op      = op_t'(ir_r[31:27]);
  assign rd      = ir_r[26:24];
  assign imm     = ir_r[15:0];
  assign addr    = ir_r[23:0];
  // In S_EX port B holds r7.
  assign dadr24  = addr + {{8{rfb_q[15]}}, rfb_q} - 24'd1;
  assign ex_dadr = dadr24[DATA_AW-1:0];

  // Execute results for the single-cycle operations; rfa_q holds rd in S_EX.
  logic              ex_we, ex_cmp, ex_ovf;
  logic [WORD_W-1:0] ex_wd;
  logic [16:0]       sum;
  logic signed [31:0] prod;
  logic [3:0]        sar_n;

  always_comb begin
    ex_we  = 1'b0;
    ex_wd  = '0;
    ex_cmp = cmp_r;
    ex_ovf = ovf_r;
    sum    = '0;
    prod   = $signed(opa_r) * $signed(opb_r);
    sar_n  = (opb_r > 16'd15) ? 4'd15 : opb_r[3:0];
    case (op)
      OP_LOADI: begin
        ex_we = 1'b1; ex_wd = imm;
      end
      OP_IN: begin
        ex_we = 1'b1; ex_wd = {rfa_q[15:8], inb_r};
      end
      OP_POP: begin
        ex_we = (rd != 3'd0); ex_wd = st_q;
      end
      OP_ADD, OP_SUB, OP_ADDI, OP_SUBI: begin
        if (op == OP_ADD) sum = {opa_r[15], opa_r} + {opb_r[15], opb_r};
        else if (op == OP_SUB) sum = {opa_r[15], opa_r} - {opb_r[15], opb_r};
        else if (op == OP_ADDI) sum = {rfa_q[15], rfa_q} + {imm[15], imm};
        else sum = {rfa_q[15], rfa_q} - {imm[15], imm};
        ex_we = 1'b1; ex_wd = sum[15:0]; ex_ovf = sum[16] ^ sum[15];
      end
      OP_MUL: begin
        ex_we  = 1'b1; ex_wd = prod[15:0];
        ex_ovf = !((prod[31:15] == 17'h0) || (prod[31:15] == 17'h1FFFF));
      end
      OP_AND: begin ex_we = 1'b1; ex_wd = opa_r & opb_r; end
      OP_OR:  begin ex_we = 1'b1; ex_wd = opa_r | opb_r; end
      OP_XOR: begin ex_we = 1'b1; ex_wd = opa_r ^ opb_r; end
      OP_NOTB: begin ex_we = 1'b1; ex_wd = ~opa_r; end
      OP_SAL: begin
        ex_we = 1'b1;
        ex_wd = (opb_r >= 16'd16) ? '0 : (opa_r << opb_r[3:0]);
      end
      OP_SAR: begin
        ex_we = 1'b1; ex_wd = $unsigned($signed(opa_r) >>> sar_n);
      end
      OP_EQU: ex_cmp = (rfa_q == opa_r);
      OP_LT:  ex_cmp = ($signed(rfa_q) < $signed(opa_r));
      OP_LTE: ex_cmp = ($signed(rfa_q) <= $signed(opa_r));
      OP_NOTC: ex_cmp = ~cmp_r;
      default: ;
    endcase
  end

  // One step of the restoring divider on magnitudes.
  logic [16:0]       div_sh, div_sub;
  assign div_sh  = {rem_r[15:0], quo_r[15]};
  assign div_sub = div_sh - {1'b0, dvs_r};

  logic in_acc, out_free, out_load;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_v_r || out_ch.ready;
  assign out_load    = (state_r == S_FIN) && out_free;

  // Memory port control.
  always_comb begin
    rfa_addr = 3'd0;
    rfb_addr = 3'd7;
    rf_we    = 1'b0;
    rf_wa    = rd;
    rf_wd    = ex_wd;
    dm_we    = 1'b0;
    dm_wa    = ex_dadr;
    dm_wd    = rfa_q[7:0];
    dm_ra    = ex_dadr;
    st_we    = 1'b0;
    fr_we    = 1'b0;
    fr_wa    = {fp_r, cnt_r[2:0]};
    fr_ra    = {fp_r, cnt_r[2:0] + 3'd1};
    fm_we    = 1'b0;
    fm_ra    = fp_r;
    unique case (state_r)
      S_IDLE: begin
        rfa_addr = in_ch.instr_word[22:20];
        rfb_addr = in_ch.instr_word[18:16];
        dm_wa    = DATA_AW'(in_ch.load_addr);
        dm_wd    = in_ch.load_byte;
        dm_we    = in_acc && !stopped_r && (in_ch.req_type == REQ_PRELOAD);
      end
      S_RD2: begin
        rfa_addr = rd;
        rfb_addr = 3'd7;
      end
      S_EX: begin
        // STOREW keeps rd on port A for its low byte; CALL starts saving from r1.
        rfa_addr = (op == OP_STOREW) ? rd : 3'd1;
        rf_we    = ex_we;
        st_we    = (op == OP_PUSH);
        dm_we    = (op == OP_STOREB) || (op == OP_STOREW);
        dm_wd    = (op == OP_STOREW) ? rfa_q[15:8] : rfa_q[7:0];
        fr_ra    = {fp_r - 1'b1, 3'd1};
        fm_ra    = fp_r - 1'b1;
      end
      S_LD1: begin
        dm_ra = dadr_r + 1'b1;
        rf_we = (op == OP_LOADB);
        rf_wd = {8'd0, dm_q};
      end
      S_LD2: begin
        rf_we = 1'b1;
        rf_wd = {hi_r, dm_q};
      end
      S_ST2: begin
        dm_we = 1'b1;
        dm_wa = dadr_r + 1'b1;
        dm_wd = rfa_q[7:0];
      end
      S_CSAVE: begin
        rfa_addr = cnt_r[2:0] + 3'd1;
        fr_we    = 1'b1;
        fm_we    = (cnt_r[2:0] == 3'd7);
      end
      S_RLOAD: begin
        rf_we = 1'b1;
        rf_wa = cnt_r[2:0];
        rf_wd = fr_q;
      end
      S_DIV: begin
        rf_we = (cnt_r == 4'd15);
        rf_wd = neg_r ? 16'(-{quo_r[14:0], !div_sub[16]})
                      : {quo_r[14:0], !div_sub[16]};
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rfa_q <= rf_vld_r[rfa_addr] ? rf_mem[rfa_addr] : '0;
    rfb_q <= rf_vld_r[rfb_addr] ? rf_mem[rfb_addr] : '0;
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dm_q <= dm_mem[dm_ra];
    if (dm_we) dm_mem[dm_wa] <= dm_wd;
  end

  // The stack is always read one entry below the pointer, ready for POP.
  always_ff @(posedge clk) begin
    st_q <= st_mem[sp_r - 1'b1];
    if (st_we) st_mem[sp_r] <= rfa_q;
  end

  always_ff @(posedge clk) begin
    fr_q <= fr_mem[fr_ra];
    fm_q <= fm_mem[fm_ra];
    if (fr_we) fr_mem[fr_wa] <= rfa_q;
    if (fm_we) fm_mem[fp_r] <= {cmp_r, ovf_r, pc_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pc_r      <= '0;
      cmp_r     <= 1'b0;
      ovf_r     <= 1'b0;
      stopped_r <= 1'b0;
      sp_r      <= '0;
      fp_r      <= '0;
      out_v_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ir_r      <= in_ch.instr_word;
            inb_r     <= in_ch.in_byte;
            res_ov_r  <= 1'b0;
            res_ob_r  <= '0;
            res_flt_r <= FAULT_NONE;
            if (stopped_r || (in_ch.req_type == REQ_PRELOAD)) state_r <= S_FIN;
            else state_r <= S_RD2;
          end
        end
        S_RD2: begin
          opa_r   <= rfa_q;
          opb_r   <= rfb_q;
          pc_r    <= pc_r + 24'd4;
          state_r <= S_EX;
        end
        S_EX: begin
          cmp_r   <= ex_cmp;
          ovf_r   <= ex_ovf;
          dadr_r  <= ex_dadr;
          state_r <= S_FIN;
          case (op)
            OP_HLT: stopped_r <= 1'b1;
            OP_JMP: pc_r <= addr;
            OP_CJMP: if (cmp_r) pc_r <= addr;
            OP_OJMP: if (ovf_r) pc_r <= addr;
            OP_CALL: begin
              cnt_r   <= 4'd1;
              state_r <= S_CSAVE;
            end
            OP_RET: begin
              fp_r    <= fp_r - 1'b1;
              cnt_r   <= 4'd1;
              state_r <= S_RLOAD;
            end
            OP_PUSH: sp_r <= sp_r + 1'b1;
            OP_POP: begin
              if (rd == 3'd0) begin
                stopped_r <= 1'b1;
                res_flt_r <= FAULT_POP_R0;
              end else begin
                sp_r <= sp_r - 1'b1;
              end
            end
            OP_LOADB, OP_LOADW: state_r <= S_LD1;
            OP_STOREW: state_r <= S_ST2;
            OP_OUT: begin
              res_ov_r <= 1'b1;
              res_ob_r <= rfa_q[7:0];
            end
            OP_DIV: begin
              if (opb_r == 16'd0) begin
                stopped_r <= 1'b1;
                res_flt_r <= FAULT_DIV0;
              end else begin
                quo_r   <= opa_r[15] ? 16'(-opa_r) : opa_r;
                dvs_r   <= opb_r[15] ? 16'(-opb_r) : opb_r;
                neg_r   <= opa_r[15] ^ opb_r[15];
                rem_r   <= '0;
                cnt_r   <= 4'd0;
                state_r <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_LD1: begin
          hi_r    <= dm_q;
          state_r <= (op == OP_LOADW) ? S_LD2 : S_FIN;
        end
        S_LD2: state_r <= S_FIN;
        S_ST2: state_r <= S_FIN;
        S_CSAVE: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r[2:0] == 3'd7) begin
            fp_r    <= fp_r + 1'b1;
            pc_r    <= addr;
            state_r <= S_FIN;
          end
        end
        S_RLOAD: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r[2:0] == 3'd7) begin
            cmp_r   <= fm_q[PC_W+1];
            ovf_r   <= fm_q[PC_W];
            pc_r    <= fm_q[PC_W-1:0];
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          rem_r <= div_sub[16] ? div_sh : div_sub;
          quo_r <= {quo_r[14:0], !div_sub[16]};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            o_pc_r   <= pc_r;
            o_ov_r   <= res_ov_r;
            o_ob_r   <= res_ob_r;
            o_halt_r <= stopped_r;
            o_flt_r  <= res_flt_r;
            o_cmp_r  <= cmp_r;
            o_ovf_r  <= ovf_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.next_pc       = o_pc_r;
  assign out_ch.out_valid     = o_ov_r;
  assign out_ch.out_byte      = o_ob_r;
  assign out_ch.halted        = o_halt_r;
  assign out_ch.fault         = o_flt_r;
  assign out_ch.compare_flag  = o_cmp_r;
  assign out_ch.overflow_flag = o_ovf_r;

endmodule
